// ----- hw/rtl/qdc_pkg.sv -----
// qdc_pkg: shared types, constants and the quarter-step table for the
// quadrature detent counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qdc_pkg;

    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned THRESH_W    = 3;
    localparam int unsigned ACC_W       = 4;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 24;

    localparam logic [COUNT_W-1:0]  COUNT_LIMIT_RST = 16'd9999;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST   = 3'd2;
    localparam logic [1:0]          PHASE_RST       = 2'b11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT_LIMIT      = 1'b0,
        REG_DETENT_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef logic signed [1:0] qstep_t;

    // Indexed by {last_phase, phase}. Double jumps and no-change give zero.
    localparam qstep_t QUARTER_STEP [16] = '{
        2'sd0,  -2'sd1,  2'sd1,  2'sd0,
        2'sd1,   2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
        2'sd0,   2'sd1, -2'sd1,  2'sd0
    };

    typedef struct packed {
        logic [1:0]              last_phase;
        logic signed [ACC_W-1:0] acc;
        logic [COUNT_W-1:0]      count;
    } qdc_state_t;

    typedef struct packed {
        logic stepped_up;
        logic stepped_down;
    } qdc_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/qdc_step.sv -----
// qdc_step: single-tick update of phase, accumulator and position count.
// Depends on qdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qdc_step (
    input  wire qdc_pkg::qdc_state_t               state_cur,
    input  wire logic [1:0]                        phase,
    input  wire logic [qdc_pkg::COUNT_W-1:0]       count_limit,
    input  wire logic [qdc_pkg::THRESH_W-1:0]      detent_threshold,
    output qdc_pkg::qdc_state_t                    state_next,
    output qdc_pkg::qdc_flags_t                    flags
);

    logic                                changed;
    qdc_pkg::qstep_t                     delta;
    logic signed [qdc_pkg::ACC_W:0]      sum;
    logic signed [qdc_pkg::ACC_W:0]      thr;
    logic                                move;
    logic                                up;
    logic                                down;

    always_comb begin
        changed = (phase != state_cur.last_phase);
        delta   = qdc_pkg::QUARTER_STEP[{state_cur.last_phase, phase}];
        move    = changed && (delta != 2'sd0);
        sum     = {state_cur.acc[qdc_pkg::ACC_W-1], state_cur.acc}
                + {{(qdc_pkg::ACC_W-1){delta[1]}}, delta};
        // zero threshold acts as one
        thr     = (detent_threshold == '0) ? (qdc_pkg::ACC_W+1)'(1)
                                           : {2'b00, detent_threshold};
        up      = move && (sum >= thr);
        down    = move && !up && (sum <= -thr);

        state_next.last_phase = phase;
        state_next.acc        = state_cur.acc;
        state_next.count      = state_cur.count;
        if (up || down) begin
            state_next.acc = '0;
        end else if (move) begin
            state_next.acc = sum[qdc_pkg::ACC_W-1:0];
        end
        if (up) begin
            state_next.count = (state_cur.count >= count_limit) ? '0
                             : state_cur.count + 1'b1;
        end else if (down) begin
            state_next.count = (state_cur.count == '0) ? count_limit
                             : state_cur.count - 1'b1;
        end

        flags.stepped_up   = up;
        flags.stepped_down = down;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/quadrature_detent_counter.sv -----
// quadrature_detent_counter: top level, stream ports, config registers,
// state and result registers. Depends on qdc_pkg and qdc_step.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  - Slave stream carries one encoder sample per transfer: clk_level in
//    s_tdata[0], dt_level in s_tdata[1]. Every accepted sample produces
//    exactly one result transfer on the master stream.
//  - Master stream: count_value in m_tdata[15:0], stepped_up in bit 16,
//    stepped_down in bit 17. Unused upper bits read zero.
//  - Latency: result is valid the cycle after the sample transfer.
//  - Throughput: one sample per clock unless a result waits on a stalled receiver.
//    The encoder state is updated in the same cycle as the transfer, so the next sample may follow at once.
//  - Stall: a single result register holds the pending result; s_tready
//    stays high while the register is empty or being drained this cycle,
//    and drops only while a result waits on a stalled receiver.
//  - Config: cfg_we writes cfg_wdata to register cfg_index (0 count_limit,
//    1 detent_threshold) at the clock edge; write only while idle.
//  - Reset (aresetn low, synchronous): last phase = both lines high,
//    accumulator and count cleared, count_limit = 9999, threshold = 2,
//    result register emptied.
module quadrature_detent_counter #(
    parameter logic [qdc_pkg::COUNT_W-1:0]  COUNT_LIMIT_RST = qdc_pkg::COUNT_LIMIT_RST,
    parameter logic [qdc_pkg::THRESH_W-1:0] THRESHOLD_RST   = qdc_pkg::THRESHOLD_RST
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config write port
    input  wire logic                              cfg_we,
    input  wire logic [qdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [qdc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // sample stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [qdc_pkg::S_TDATA_W-1:0]     s_tdata,  // [0] clk_level, [1] dt_level
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [qdc_pkg::M_TDATA_W-1:0]          m_tdata   // [15:0] count_value,
                                                             // [16] stepped_up,
                                                             // [17] stepped_down
);

    // config registers
    logic [qdc_pkg::COUNT_W-1:0]  count_limit_reg;
    logic [qdc_pkg::THRESH_W-1:0] threshold_reg;

    // encoder state
    qdc_pkg::qdc_state_t state_reg;
    qdc_pkg::qdc_state_t state_next;
    qdc_pkg::qdc_flags_t flags_next;

    // result register
    logic                          out_valid_reg;
    logic [qdc_pkg::COUNT_W-1:0]   out_count_reg;
    qdc_pkg::qdc_flags_t           out_flags_reg;

    logic       in_xfer;
    logic [1:0] phase;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    // phase = {clk, dt}
    assign phase    = {s_tdata[0], s_tdata[1]};

    qdc_step u_step (
        .state_cur        (state_reg),
        .phase            (phase),
        .count_limit      (count_limit_reg),
        .detent_threshold (threshold_reg),
        .state_next       (state_next),
        .flags            (flags_next)
    );

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_limit_reg <= COUNT_LIMIT_RST;
            threshold_reg   <= THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (qdc_pkg::cfg_reg_t'(cfg_index))
                qdc_pkg::REG_COUNT_LIMIT: begin
                    count_limit_reg <= cfg_wdata;
                end
                qdc_pkg::REG_DETENT_THRESHOLD: begin
                    threshold_reg <= cfg_wdata[qdc_pkg::THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // state advances on every sample transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.last_phase <= qdc_pkg::PHASE_RST;
            state_reg.acc        <= '0;
            state_reg.count      <= '0;
        end else if (in_xfer) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            out_count_reg <= state_next.count;
            out_flags_reg <= flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(qdc_pkg::M_TDATA_W - qdc_pkg::COUNT_W - 2){1'b0}},
                       out_flags_reg.stepped_down, out_flags_reg.stepped_up,
                       out_count_reg};

endmodule

`default_nettype wire

// ----- hw/rtl/qdc_checker.sv -----
// qdc_checker: port-level assertions for quadrature_detent_counter, bound
// to the top level. Depends on qdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qdc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [qdc_pkg::M_TDATA_W-1:0]     m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every sample transfer yields a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("missing result after sample transfer");

    // never step both ways on one sample
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
        else $error("up and down both set");

    // empty result stage never blocks input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // no result appears without a sample
    a_noinvent: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result without sample");

endmodule

bind quadrature_detent_counter qdc_checker u_qdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
